>>> rtl/core/aczs_pkg.sv
// ----------------------------------------------------------------------------
// aczs_pkg: shared types and constants of the zone-scoring matcher
// Item layouts, kind codes, zone codes and the scan sequencer states.
// ----------------------------------------------------------------------------
package aczs_pkg;

  localparam int NUM_STATES    = 256;
  localparam int STATE_W       = $clog2(NUM_STATES);
  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int GOTO_AW       = STATE_W + SYM_W;
  localparam int HOP_W         = STATE_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_ZONE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HEADER = 1'd1;

  localparam logic [3:0] ZONE_ANY          = 4'd0;
  localparam logic [3:0] ZONE_HEADER       = 4'd1;
  localparam logic [3:0] ZONE_NAMED_HEADER = 4'd2;

  typedef enum logic [1:0] {
    KIND_GOTO = 2'd0,
    KIND_NODE = 2'd1,
    KIND_SCAN = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  node_id;
    logic [7:0]  byte_value;
    logic [7:0]  child_state;
    logic [7:0]  fail_state;
    logic        has_rule;
    logic [15:0] rule_points;
    logic [3:0]  rule_zone_code;
    logic [7:0]  rule_header_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_score;
    logic        any_match;
  } out_item_t;

  // Node record held in the node memory.
  typedef struct packed {
    logic [STATE_W-1:0] fail;
    logic               valid;
    logic [15:0]        points;
    logic [3:0]         zone;
    logic [7:0]         header;
  } node_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL_RD,
    ST_FAIL_CHK,
    ST_OUT_RD,
    ST_OUT_CHK,
    ST_RESULT
  } seq_state_t;

endpackage

>>> rtl/core/aczs_goto_mem.sv
// ----------------------------------------------------------------------------
// aczs_goto_mem: goto table
// One write and one read port; read data after one cycle. The top level
// clears every entry with a pass of zero writes after reset.
// ----------------------------------------------------------------------------
module aczs_goto_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [aczs_pkg::GOTO_AW-1:0] waddr,
  input  logic [aczs_pkg::STATE_W-1:0] wdata,
  input  logic [aczs_pkg::GOTO_AW-1:0] raddr,
  output logic [aczs_pkg::STATE_W-1:0] rdata
);
  import aczs_pkg::*;

  logic [STATE_W-1:0] mem [2**GOTO_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/aczs_node_mem.sv
// ----------------------------------------------------------------------------
// aczs_node_mem: node record memory
// Failure link and rule data per state, one write and one read port.
// ----------------------------------------------------------------------------
module aczs_node_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [aczs_pkg::STATE_W-1:0] waddr,
  input  aczs_pkg::node_rec_t          wdata,
  input  logic [aczs_pkg::STATE_W-1:0] raddr,
  output aczs_pkg::node_rec_t          rdata
);
  import aczs_pkg::*;

  node_rec_t mem [NUM_STATES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/aho_corasick_zone_score_matcher.sv
// ----------------------------------------------------------------------------
// aho_corasick_zone_score_matcher: Aho-Corasick scanner with zone scoring
// Loads goto entries and node records, scans bytes, reports score per buffer.
// ----------------------------------------------------------------------------
// Load transactions are written to their memory when accepted. A scan byte
// takes a read state and a check state per failure hop and for the child
// lookup, then a read state and a check state per node on the output chain;
// every step waits on a registered read of the goto memory or the node
// memory. An end transaction registers the result. After reset the block
// clears the goto memory, one entry per cycle, before it accepts any
// transaction; the node records are cleared during the same pass.
// Configuration writes are taken throughout.
module aho_corasick_zone_score_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  aczs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output aczs_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [aczs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aczs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aczs_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [3:0]         zone_r;
  logic [7:0]         header_r;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic [STATE_W-1:0] walk_r, walk_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [HOP_W-1:0]   hops_r, hops_nxt;
  logic               looked_r, looked_nxt;  // child lookup issued (final read)
  logic [31:0]        score_r, score_nxt;
  logic               match_r, match_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               clr_r;
  logic [GOTO_AW-1:0] clr_addr_r;

  logic               g_we;
  logic [GOTO_AW-1:0] g_waddr, g_raddr;
  logic [STATE_W-1:0] g_wdata, g_rdata;
  logic               n_we;
  node_rec_t          n_wdata, n_rdata;
  logic [STATE_W-1:0] n_raddr, n_waddr;

  aczs_goto_mem u_goto (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );
  aczs_node_mem u_node (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  logic accept;
  assign in_ready = rst_n && !clr_r && state_r == ST_IDLE
                    && !(in_data.kind == KIND_END && out_valid_r);
  assign accept   = in_valid && in_ready;

  // Load writes. With 256 states every 8-bit id is in range.
  always_comb begin
    g_we    = clr_r || (accept && in_data.kind == KIND_GOTO);
    g_waddr = clr_r ? clr_addr_r : {in_data.node_id[STATE_W-1:0], in_data.byte_value};
    g_wdata = clr_r ? '0 : in_data.child_state[STATE_W-1:0];
    n_we    = clr_r || (accept && in_data.kind == KIND_NODE);
    n_waddr = clr_r ? clr_addr_r[STATE_W-1:0] : in_data.node_id[STATE_W-1:0];
    n_wdata = '0;
    if (!clr_r) begin
      n_wdata.fail   = in_data.fail_state[STATE_W-1:0];
      n_wdata.valid  = in_data.has_rule;
      n_wdata.points = in_data.rule_points;
      n_wdata.zone   = in_data.rule_zone_code;
      n_wdata.header = in_data.rule_header_id;
    end
  end

  logic        zone_ok;
  logic [32:0] sum_w;
  always_comb begin
    zone_ok = (n_rdata.zone == ZONE_ANY)
           || (n_rdata.zone != ZONE_NAMED_HEADER && n_rdata.zone == zone_r)
           || (n_rdata.zone == ZONE_NAMED_HEADER && zone_r == ZONE_HEADER
               && header_r != 8'd0 && n_rdata.header == header_r);
    sum_w = {1'b0, score_r} + {17'd0, n_rdata.points};
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    walk_nxt      = walk_r;
    sym_nxt       = sym_r;
    hops_nxt      = hops_r;
    looked_nxt    = looked_r;
    score_nxt     = score_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    g_raddr       = {walk_r, sym_r};
    n_raddr       = walk_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.kind == KIND_SCAN) begin
          sym_nxt    = in_data.byte_value;
          walk_nxt   = cur_r;
          hops_nxt   = '0;
          looked_nxt = 1'b0;
          state_nxt  = ST_FAIL_RD;
        end else if (accept && in_data.kind == KIND_END) begin
          out_nxt.total_score = score_r;
          out_nxt.any_match   = match_r;
          out_valid_nxt = 1'b1;
          score_nxt = '0;
          match_nxt = 1'b0;
          cur_nxt   = '0;
        end
      end
      ST_FAIL_RD: begin
        // Read the goto entry and the node record of walk_r together.
        state_nxt = ST_FAIL_CHK;
      end
      ST_FAIL_CHK: begin
        if (looked_r || walk_r == '0 || g_rdata != '0) begin
          if (walk_r == '0 || looked_r || g_rdata != '0) begin
            walk_nxt = g_rdata;
            cur_nxt  = g_rdata;
            hops_nxt = '0;
            state_nxt = (g_rdata == '0) ? ST_IDLE : ST_OUT_RD;
          end
        end else if (hops_r >= HOP_W'(NUM_STATES)) begin
          walk_nxt   = '0;
          looked_nxt = 1'b1;
          state_nxt  = ST_FAIL_RD;
        end else begin
          walk_nxt  = n_rdata.fail;
          hops_nxt  = hops_r + 1'b1;
          state_nxt = ST_FAIL_RD;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_CHK;
      end
      ST_OUT_CHK: begin
        if (n_rdata.valid && zone_ok) begin
          match_nxt = 1'b1;
          score_nxt = sum_w[32] ? '1 : sum_w[31:0];
        end
        walk_nxt = n_rdata.fail;
        hops_nxt = hops_r + 1'b1;
        state_nxt = (n_rdata.fail == '0 || hops_r + 1'b1 >= HOP_W'(NUM_STATES))
                    ? ST_IDLE : ST_OUT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zone_r      <= 4'd3;
      header_r    <= 8'd0;
      cur_r       <= '0;
      score_r     <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      score_r     <= score_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEARCH_ZONE:   zone_r   <= cfg_wdata[3:0];
          CFG_SEARCH_HEADER: header_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_r   <= walk_nxt;
    sym_r    <= sym_nxt;
    hops_r   <= hops_nxt;
    looked_r <= looked_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result is only raised by an end transaction taken while idle.
  a_out_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid_r) && out_valid_r |-> $past(accept && in_data.kind == KIND_END))
    else $error("result without end transaction");
  // No transaction is taken during the clearing pass.
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready)
    else $error("accepted during clear");
  // An end transaction returns the scanner to the root with a cleared score.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.kind == KIND_END |=> cur_r == '0 && score_r == '0 && !match_r)
    else $error("end did not reset scan state");
endmodule
